// ----- rtl/core/pip_pkg.sv -----
`timescale 1ns / 1ps
package pip_pkg;

  // coordinate and arithmetic widths
  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MAG_W   = COORD_W;
  localparam int PROD_W  = 2 * MAG_W;

  // polygon store
  localparam int DEF_MAX_VERTICES = 64;
  localparam int MIN_VERTICES     = 3;

  // word kinds on the input channel
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_DROP = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  // edge handed from the sequencer to the edge unit
  typedef struct packed {
    logic    clr;
    logic    vld;
    vertex_t vi;
    vertex_t vj;
  } edge_req_t;

  typedef struct packed {
    logic busy;
    logic parity;
  } edge_sts_t;

endpackage

// ----- rtl/core/pip_in_if.sv -----
`timescale 1ns / 1ps
interface pip_in_if
  import pip_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   kind;
  logic   new_polygon;
  coord_t coord_x;
  coord_t coord_y;

  modport source (output valid, output kind, output new_polygon, output coord_x,
                  output coord_y, input ready);
  modport sink   (input valid, input kind, input new_polygon, input coord_x,
                  input coord_y, output ready);
endinterface

// ----- rtl/core/pip_out_if.sv -----
`timescale 1ns / 1ps
interface pip_out_if;
  logic       valid;
  logic       ready;
  logic       inside_res;
  logic [1:0] status;

  modport source (output valid, output inside_res, output status, input ready);
  modport sink   (input valid, input inside_res, input status, output ready);
endinterface

// ----- rtl/core/point_in_polygon_test.sv -----
`timescale 1ns / 1ps
// Even-odd point-in-polygon test. Vertex words append one vertex (new_polygon
// first empties the list) without leaving the idle state; beyond MAX_VERTICES
// they are dropped and later queries report status 2. A query word against a
// polygon of three or more vertices circulates the whole vertex chain once
// past a single three-stage edge unit, one edge per cycle; the sequencer then
// drains the edge pipeline and, in its finish state, loads the result word
// into the output register as soon as that register is free or being taken.
// A query against fewer than three vertices skips the scan and drain and
// answers with status 1. The input side takes no word until the result word
// is loaded, but a loaded result waits in the output register without
// blocking input.
module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic         clk,
  input  logic         rst_n,
  pip_in_if.sink       in_ch,
  pip_out_if.source    out_ch
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_VERTICES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, step_r, step_nxt, cnt_base;
  logic             ovf_r, ovf_nxt;
  coord_t           qx_r, qy_r;
  vertex_t          first_r, prev_r, new_vtx, tail_vtx;
  logic             few_r, few_nxt;
  logic [1:0]       pend_st_r, pend_st_nxt;
  logic             out_valid_r, out_inside_r;
  logic [1:0]       out_status_r;

  logic             accept, is_vertex, is_query, append;
  logic             shift_en, rotate, scanning, at_end, elem_valid, elem_first, load_out;
  logic [CNT_W:0]   pos_sum;
  edge_req_t        req;
  edge_sts_t        sts;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_vertex   = accept && (in_ch.kind == KIND_VERTEX);
  assign is_query    = accept && (in_ch.kind == KIND_QUERY);

  // append position after an optional restart
  assign cnt_base = in_ch.new_polygon ? '0 : count_r;
  assign append   = is_vertex && (cnt_base < MAX_CNT);
  assign new_vtx  = '{x: in_ch.coord_x, y: in_ch.coord_y};

  // scan position: the tail holds vertex step - (MAX - count)
  assign scanning   = (state_r == S_SCAN);
  assign at_end     = (step_r == MAX_CNT);
  assign pos_sum    = {1'b0, step_r} + {1'b0, count_r};
  assign elem_valid = scanning && !at_end && (pos_sum >= {1'b0, MAX_CNT});
  assign elem_first = scanning && !at_end && (pos_sum == {1'b0, MAX_CNT});

  assign rotate   = scanning && !at_end;
  assign shift_en = append || rotate;

  pip_chain #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_chain (
    .clk      (clk),
    .shift_en (shift_en),
    .rotate   (rotate),
    .new_vtx  (new_vtx),
    .tail_vtx (tail_vtx)
  );

  // feed one edge per cycle; the closing edge pairs vertex 0 with the last
  always_comb begin
    req.clr = is_query;
    req.vld = scanning && (at_end || (elem_valid && !elem_first));
    req.vi  = at_end ? first_r : tail_vtx;
    req.vj  = prev_r;
  end

  pip_edge u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .qx    (qx_r),
    .qy    (qy_r),
    .req   (req),
    .sts   (sts)
  );

  // track first and previous vertex of the scan
  always_ff @(posedge clk) begin
    if (elem_first) begin
      first_r <= tail_vtx;
    end
    if (elem_valid) begin
      prev_r <= tail_vtx;
    end
    if (is_query) begin
      qx_r <= in_ch.coord_x;
      qy_r <= in_ch.coord_y;
    end
  end

  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // sequencer and polygon bookkeeping
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    step_nxt    = step_r;
    few_nxt     = few_r;
    pend_st_nxt = pend_st_r;
    unique case (state_r)
      S_IDLE: begin
        if (is_vertex) begin
          ovf_nxt = in_ch.new_polygon ? 1'b0 : ovf_r;
          if (append) begin
            count_nxt = cnt_base + CNT_W'(1);
          end else begin
            count_nxt = cnt_base;
            ovf_nxt   = 1'b1;
          end
        end else if (is_query) begin
          step_nxt = '0;
          if (count_r < MIN_CNT) begin
            few_nxt     = 1'b1;
            pend_st_nxt = ST_FEW;
            state_nxt   = S_FIN;
          end else begin
            few_nxt     = 1'b0;
            pend_st_nxt = ovf_r ? ST_DROP : ST_OK;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (at_end) begin
          state_nxt = S_DRAIN;
        end else begin
          step_nxt = step_r + CNT_W'(1);
        end
      end
      S_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    few_r     <= few_nxt;
    pend_st_r <= pend_st_nxt;
  end

  // output register: load the result word, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_inside_r <= few_r ? 1'b0 : sts.parity;
      out_status_r <= pend_st_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.inside_res = out_inside_r;
  assign out_ch.status     = out_status_r;

endmodule

// ----- rtl/core/pip_cell.sv -----
`timescale 1ns / 1ps
module pip_cell
  import pip_pkg::*;
(
  input  logic    clk,
  input  logic    shift_en,
  input  vertex_t vtx_in,
  output vertex_t vtx_out
);

  vertex_t vtx_r;

  // take the neighbor's vertex on a shift, hold otherwise
  always_ff @(posedge clk) begin
    if (shift_en) begin
      vtx_r <= vtx_in;
    end
  end

  assign vtx_out = vtx_r;

endmodule

// ----- rtl/core/pip_chain.sv -----
`timescale 1ns / 1ps
module pip_chain
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic    clk,
  input  logic    shift_en,
  input  logic    rotate,
  input  vertex_t new_vtx,
  output vertex_t tail_vtx
);

  vertex_t link [MAX_VERTICES];
  vertex_t head_in;

  // head takes a new vertex on append, or the tail when circulating
  assign head_in  = rotate ? link[MAX_VERTICES-1] : new_vtx;
  assign tail_vtx = link[MAX_VERTICES-1];

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    if (k == 0) begin : g_head
      pip_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .vtx_in   (head_in),
        .vtx_out  (link[k])
      );
    end else begin : g_body
      pip_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .vtx_in   (link[k-1]),
        .vtx_out  (link[k])
      );
    end
  end

endmodule

// ----- rtl/core/pip_edge.sv -----
`timescale 1ns / 1ps
module pip_edge
  import pip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  coord_t    qx,
  input  coord_t    qy,
  input  edge_req_t req,
  output edge_sts_t sts
);

  logic signed [DIFF_W-1:0] a1, a2, b1, b2;
  logic                     spans, up;

  logic             s1_vld_r, s1_spans_r, s1_up_r, s1_sa_r, s1_sb_r;
  logic [MAG_W-1:0] s1_a1_r, s1_a2_r, s1_b1_r, s1_b2_r;

  logic              s2_vld_r, s2_spans_r, s2_up_r, s2_sa_r, s2_sb_r;
  logic [PROD_W-1:0] s2_ma_r, s2_mb_r;

  logic na, nb, c_neg, c_pos, left, toggle;
  logic parity_r;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] n;
    n = -d;
    return d[DIFF_W-1] ? n[MAG_W-1:0] : d[MAG_W-1:0];
  endfunction

  // differences of the crossing test and span check
  always_comb begin
    a1    = DIFF_W'(qx) - DIFF_W'(req.vi.x);
    a2    = DIFF_W'(req.vj.y) - DIFF_W'(req.vi.y);
    b1    = DIFF_W'(req.vj.x) - DIFF_W'(req.vi.x);
    b2    = DIFF_W'(qy) - DIFF_W'(req.vi.y);
    spans = ((req.vi.y <= qy) && (qy < req.vj.y)) ||
            ((req.vj.y <= qy) && (qy < req.vi.y));
    up    = req.vj.y > req.vi.y;
  end

  // stage 1: magnitudes and product signs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= req.vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_spans_r <= spans;
    s1_up_r    <= up;
    s1_sa_r    <= a1[DIFF_W-1] ^ a2[DIFF_W-1];
    s1_sb_r    <= b1[DIFF_W-1] ^ b2[DIFF_W-1];
    s1_a1_r    <= mag_of(a1);
    s1_a2_r    <= mag_of(a2);
    s1_b1_r    <= mag_of(b1);
    s1_b2_r    <= mag_of(b2);
  end

  // stage 2: unsigned products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_spans_r <= s1_spans_r;
    s2_up_r    <= s1_up_r;
    s2_sa_r    <= s1_sa_r;
    s2_sb_r    <= s1_sb_r;
    s2_ma_r    <= PROD_W'(s1_a1_r) * PROD_W'(s1_a2_r);
    s2_mb_r    <= PROD_W'(s1_b1_r) * PROD_W'(s1_b2_r);
  end

  // stage 3: signed compare of the two products
  always_comb begin
    na = s2_sa_r && (s2_ma_r != '0);
    nb = s2_sb_r && (s2_mb_r != '0);
    if (na != nb) begin
      c_neg = na;
      c_pos = !na;
    end else begin
      c_neg = na ? (s2_ma_r > s2_mb_r) : (s2_ma_r < s2_mb_r);
      c_pos = na ? (s2_ma_r < s2_mb_r) : (s2_ma_r > s2_mb_r);
    end
    left   = s2_up_r ? c_neg : c_pos;
    toggle = s2_vld_r && s2_spans_r && left;
  end

  // clear at query start, flip on each crossing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r <= 1'b0;
    end else if (req.clr) begin
      parity_r <= 1'b0;
    end else if (toggle) begin
      parity_r <= !parity_r;
    end
  end

  assign sts.busy   = s1_vld_r | s2_vld_r;
  assign sts.parity = parity_r;

endmodule

// ----- dv/pip_crossing_checker.sv -----
`timescale 1ns / 1ps
module pip_crossing_checker
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic clk,
  input  logic rst_n,
  pip_in_if    in_mon,
  pip_out_if   out_mon,
  output int   mismatches,
  output int   answers_due,
  output int   answers_checked,
  output int   answers_inside,
  output int   answers_few,
  output int   answers_dropped
);

  typedef struct packed {
    logic       inside_res;
    logic [1:0] status;
  } answer_t;

  coord_t  poly_x [MAX_VERTICES];
  coord_t  poly_y [MAX_VERTICES];
  int      poly_len = 0;
  logic    poly_overflow = 1'b0;
  answer_t expected_answers [$];
  int      n_err = 0;
  int      n_chk = 0;
  int      n_in = 0;
  int      n_few = 0;
  int      n_drop = 0;

  // exact crossing test of edge (i, j) against the rightward ray from (qx, qy)
  function automatic logic edge_flips(coord_t xi, coord_t yi, coord_t xj, coord_t yj,
                                      coord_t qx, coord_t qy);
    logic signed [COORD_W:0]     dqx, dey, dex, dqy;
    logic signed [2*COORD_W+3:0] lhs, rhs;
    if (!((yi <= qy && qy < yj) || (yj <= qy && qy < yi)))
      return 1'b0;
    dqx = {qx[COORD_W-1], qx} - {xi[COORD_W-1], xi};
    dey = {yj[COORD_W-1], yj} - {yi[COORD_W-1], yi};
    dex = {xj[COORD_W-1], xj} - {xi[COORD_W-1], xi};
    dqy = {qy[COORD_W-1], qy} - {yi[COORD_W-1], yi};
    lhs = dqx * dey;
    rhs = dex * dqy;
    // flip the comparison when the edge runs downward
    return (yj > yi) ? (lhs < rhs) : (lhs > rhs);
  endfunction

  // even-odd parity over every stored edge
  function automatic answer_t predict_answer(coord_t qx, coord_t qy);
    answer_t a;
    int      j;
    a.inside_res = 1'b0;
    a.status     = poly_overflow ? ST_DROP : ST_OK;
    if (poly_len < MIN_VERTICES) begin
      a.status = ST_FEW;
      return a;
    end
    j = poly_len - 1;
    for (int i = 0; i < poly_len; i++) begin
      if (edge_flips(poly_x[i], poly_y[i], poly_x[j], poly_y[j], qx, qy))
        a.inside_res = ~a.inside_res;
      j = i;
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (!rst_n) begin
      poly_len      = 0;
      poly_overflow = 1'b0;
      expected_answers.delete();
    end else begin
      // track the polygon and queue an answer for each query word
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KIND_VERTEX) begin
          if (in_mon.new_polygon) begin
            poly_len      = 0;
            poly_overflow = 1'b0;
          end
          if (poly_len < MAX_VERTICES) begin
            poly_x[poly_len] = in_mon.coord_x;
            poly_y[poly_len] = in_mon.coord_y;
            poly_len++;
          end else begin
            poly_overflow = 1'b1;
          end
        end else begin
          expected_answers.push_back(predict_answer(in_mon.coord_x, in_mon.coord_y));
        end
      end
      // compare each result word with the oldest open answer
      if (out_mon.valid && out_mon.ready) begin
        got.inside_res = out_mon.inside_res;
        got.status     = out_mon.status;
        if (expected_answers.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("unexpected result word: inside_res %0b status %0d",
                     got.inside_res, got.status);
        end else begin
          want = expected_answers.pop_front();
          n_chk++;
          if (got.inside_res !== want.inside_res || got.status !== want.status) begin
            n_err++;
            if (n_err <= 10)
              $display("result %0d mismatch: expected inside_res %0b status %0d, got %0b %0d",
                       n_chk, want.inside_res, want.status, got.inside_res, got.status);
          end
          if (want.inside_res)
            n_in++;
          if (want.status == ST_FEW)
            n_few++;
          if (want.status == ST_DROP)
            n_drop++;
        end
      end
    end
    mismatches      <= n_err;
    answers_due     <= expected_answers.size();
    answers_checked <= n_chk;
    answers_inside  <= n_in;
    answers_few     <= n_few;
    answers_dropped <= n_drop;
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import pip_pkg::*;

  localparam int     WORD_TARGET  = 525;
  localparam int     STALL_HOLD   = 400;
  localparam int     IDLE_LIMIT   = 3000;
  localparam int     DRAIN_CYCLES = DEF_MAX_VERTICES + 40;
  localparam coord_t C_MIN        = 32'sh8000_0000;
  localparam coord_t C_MAX        = 32'sh7fff_ffff;

  typedef enum int {SPREAD_TINY, SPREAD_MID, SPREAD_WIDE, SPREAD_FULL, SPREAD_EDGE} spread_t;

  logic   clk;
  logic   rst_n;
  int     mismatches, answers_due, answers_checked;
  int     answers_inside, answers_few, answers_dropped;
  int     words_sent = 0;
  int     vertices_sent = 0;
  int     queries_sent = 0;
  int     idle_cycles;
  bit     sender_burst = 1'b0;
  coord_t ring_x [$];
  coord_t ring_y [$];

  pip_in_if  in_ch ();
  pip_out_if out_ch ();

  point_in_polygon_test uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pip_crossing_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatches      (mismatches),
    .answers_due     (answers_due),
    .answers_checked (answers_checked),
    .answers_inside  (answers_inside),
    .answers_few     (answers_few),
    .answers_dropped (answers_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t rand_coord(spread_t spread);
    case (spread)
      SPREAD_TINY: return coord_t'($urandom_range(0, 32)) - 16;
      SPREAD_MID:  return coord_t'($urandom_range(0, 131072)) - 65536;
      SPREAD_WIDE: return coord_t'($urandom) >>> 1;
      SPREAD_FULL: return coord_t'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       return C_MIN;
          1:       return C_MAX;
          2:       return 0;
          3:       return -1;
          default: return coord_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // offer one word after an optional gap and hold it until taken
  task automatic offer_word(logic k, logic np, coord_t x, coord_t y);
    int gap;
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= k;
    in_ch.new_polygon <= np;
    in_ch.coord_x     <= x;
    in_ch.coord_y     <= y;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    words_sent++;
    if (k == KIND_VERTEX) begin
      vertices_sent++;
      if (np) begin
        ring_x.delete();
        ring_y.delete();
      end
      ring_x.push_back(x);
      ring_y.push_back(y);
    end else begin
      queries_sent++;
    end
  endtask

  // result side: random stalls, steady stretches, and one long hold-off
  initial begin
    int stall;
    int taken;
    bit held;
    bit steady;
    stall  = 0;
    taken  = 0;
    held   = 1'b0;
    steady = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        taken++;
        if (taken % 50 == 0)
          steady = ($urandom_range(0, 2) == 0);
        if (!held && taken == 40) begin
          stall = STALL_HOLD;
          held  = 1'b1;
        end else if (!steady && stall == 0) begin
          stall = pick_gap();
        end
      end else if (!steady && stall == 0 && $urandom_range(0, 7) == 0) begin
        stall = pick_gap();
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: end the run when no word moves for too long
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no word moved for %0d cycles, %0d results still due", IDLE_LIMIT,
                 answers_due);
        $display("point_in_polygon_test regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int      r;
    int      n_vert;
    int      n_query;
    int      idx;
    bit      fresh;
    bit      first;
    spread_t spread;
    coord_t  qx;
    coord_t  qy;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_VERTEX;
    in_ch.new_polygon = 1'b0;
    in_ch.coord_x     = '0;
    in_ch.coord_y     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // too few vertices, growing one vertex at a time
    offer_word(KIND_QUERY, 1'b1, 0, 0);
    offer_word(KIND_VERTEX, 1'b1, 0, 0);
    offer_word(KIND_QUERY, 1'b0, 5, 5);
    offer_word(KIND_VERTEX, 1'b0, 100, 0);
    offer_word(KIND_QUERY, 1'b0, 5, 5);
    offer_word(KIND_VERTEX, 1'b0, 0, 100);
    // small triangle: interior, outside, vertex, on and near the slanted edge
    offer_word(KIND_QUERY, 1'b0, 10, 10);
    offer_word(KIND_QUERY, 1'b1, -1, 10);
    offer_word(KIND_QUERY, 1'b0, 0, 0);
    offer_word(KIND_QUERY, 1'b0, 50, 50);
    offer_word(KIND_QUERY, 1'b0, 49, 50);
    // full-range square drives the widest products
    offer_word(KIND_VERTEX, 1'b1, C_MIN, C_MIN);
    offer_word(KIND_VERTEX, 1'b0, C_MAX, C_MIN);
    offer_word(KIND_VERTEX, 1'b0, C_MAX, C_MAX);
    offer_word(KIND_VERTEX, 1'b0, C_MIN, C_MAX);
    offer_word(KIND_QUERY, 1'b0, 0, 0);
    offer_word(KIND_QUERY, 1'b0, C_MIN, C_MIN);
    offer_word(KIND_QUERY, 1'b1, C_MAX, C_MAX);
    offer_word(KIND_QUERY, 1'b0, C_MIN, C_MAX - 1);
    offer_word(KIND_QUERY, 1'b0, -1, -1);
    // steep sliver across the whole range
    offer_word(KIND_VERTEX, 1'b1, C_MIN, C_MIN);
    offer_word(KIND_VERTEX, 1'b0, C_MAX, -1);
    offer_word(KIND_VERTEX, 1'b0, C_MIN, C_MAX);
    offer_word(KIND_QUERY, 1'b0, C_MAX, C_MIN);
    offer_word(KIND_QUERY, 1'b0, C_MAX - 1, -1);
    offer_word(KIND_QUERY, 1'b0, C_MIN, 0);

    // random polygons followed by queries; the first one overflows the store
    first = 1'b1;
    while (words_sent < WORD_TARGET) begin
      spread = spread_t'($urandom_range(0, 4));
      r      = $urandom_range(0, 99);
      if (first)
        n_vert = DEF_MAX_VERTICES + 3;
      else if (r < 8)
        n_vert = $urandom_range(0, 2);
      else if (r < 94)
        n_vert = $urandom_range(3, 10);
      else
        n_vert = $urandom_range(DEF_MAX_VERTICES - 4, DEF_MAX_VERTICES + 6);
      fresh        = ($urandom_range(0, 9) != 0);
      sender_burst = ($urandom_range(0, 3) == 0);
      for (int v = 0; v < n_vert; v++)
        offer_word(KIND_VERTEX, (v == 0) ? fresh : ($urandom_range(0, 63) == 0),
                   rand_coord(spread), rand_coord(spread));
      n_query = $urandom_range(1, 8);
      for (int q = 0; q < n_query; q++) begin
        // aim some queries at stored coordinates to hit the boundary rules
        if (ring_x.size() != 0 && $urandom_range(0, 2) == 0) begin
          idx = $urandom_range(0, ring_x.size() - 1);
          qx  = ring_x[idx] + coord_t'($urandom_range(0, 2)) - 1;
        end else begin
          qx = rand_coord(spread);
        end
        if (ring_y.size() != 0 && $urandom_range(0, 2) == 0) begin
          idx = $urandom_range(0, ring_y.size() - 1);
          qy  = ring_y[idx] + coord_t'($urandom_range(0, 2)) - 1;
        end else begin
          qy = rand_coord(spread);
        end
        offer_word(KIND_QUERY, logic'($urandom_range(0, 1)), qx, qy);
      end
      first = 1'b0;
    end

    // drain and settle
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (answers_due != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words: %0d vertices and %0d queries", words_sent, vertices_sent,
             queries_sent);
    $display("checked %0d results: %0d inside, %0d short polygon, %0d after overflow",
             answers_checked, answers_inside, answers_few, answers_dropped);
    if (mismatches == 0 && answers_due == 0)
      $display("point_in_polygon_test regression: pass");
    else
      $display("point_in_polygon_test regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pip_pkg.sv
rtl/core/pip_in_if.sv
rtl/core/pip_out_if.sv
rtl/core/pip_cell.sv
rtl/core/pip_chain.sv
rtl/core/pip_edge.sv
rtl/core/point_in_polygon_test.sv
dv/pip_crossing_checker.sv
dv/testbench.sv
